// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dcc_enc_pkg.sv =====
// Types, codes and constants of the DCC locomotive packet encoder.
package dcc_enc_pkg;

  localparam int unsigned PktMaxBytes = 5;
  localparam int unsigned PktIdxW     = $clog2(PktMaxBytes);
  localparam int unsigned PktLenW     = $clog2(PktMaxBytes + 1);

  // Packet kinds
  localparam logic [3:0] KindSpeed    = 4'd0;
  localparam logic [3:0] KindF0F4     = 4'd1;
  localparam logic [3:0] KindF5F8     = 4'd2;
  localparam logic [3:0] KindF9F12    = 4'd3;
  localparam logic [3:0] KindExtFirst = 4'd4;
  localparam logic [3:0] KindExtLast  = 4'd10;

  // Speed step modes
  localparam logic [1:0] Mode14  = 2'd0;
  localparam logic [1:0] Mode28  = 2'd1;
  localparam logic [1:0] Mode128 = 2'd2;

  localparam logic [6:0] Spd14Max  = 7'd14;
  localparam logic [6:0] Spd28Max  = 7'd28;
  localparam logic [6:0] Spd128Max = 7'd126;

  localparam logic [7:0] LongAddrTag  = 8'hc0;
  localparam logic [7:0] Adv128Code   = 8'h3f;
  localparam logic [7:0] FwdBit128    = 8'h80;
  localparam logic [7:0] SpeedTag     = 8'h40;
  localparam logic [7:0] FwdBitBase   = 8'h20;
  localparam logic [7:0] GrpF0F4Tag   = 8'h80;
  localparam logic [7:0] GrpF5F8Tag   = 8'hb0;
  localparam logic [7:0] GrpF9F12Tag  = 8'ha0;

  typedef struct packed {
    logic [13:0] loco_address;
    logic [3:0]  packet_kind;
    logic [1:0]  step_mode;
    logic        forward;
    logic [6:0]  speed;
    logic [63:0] functions_low;
    logic [4:0]  functions_high;
  } req_t;

  typedef struct packed {
    logic                              ok;
    logic [PktLenW-1:0]                len;
    logic [PktMaxBytes-1:0][7:0]       bytes;
  } pkt_t;

  typedef struct packed {
    logic               busy;
    logic [PktIdxW-1:0] idx;
    logic [PktLenW-1:0] len;
  } ser_stat_t;

  // Instruction byte of the extended function groups F13-20 through F61-68.
  function automatic logic [7:0] ext_group_code(input logic [2:0] grp);
    logic [7:0] code;
    unique case (grp)
      3'd0:    code = 8'hde;
      3'd1:    code = 8'hdf;
      3'd2:    code = 8'hd8;
      3'd3:    code = 8'hd9;
      3'd4:    code = 8'hda;
      3'd5:    code = 8'hdb;
      3'd6:    code = 8'hdc;
      default: code = 8'hdc;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/dcc_enc_build.sv =====
// Packet former: turns one registered request into its bytes and error byte.
module dcc_enc_build import dcc_enc_pkg::*; (
  input  req_t req_i,
  output pkt_t pkt_o
);

  logic        long_addr;
  logic [7:0]  addr_b0;
  logic [7:0]  addr_b1;
  logic [7:0]  data_b0;
  logic [7:0]  data_b1;
  logic        two_data;
  logic        kind_ok;
  logic [7:0]  chk;
  logic [6:0]  spd_sat;
  logic [6:0]  spd_code;
  logic [4:0]  v28;
  logic [2:0]  grp;
  logic [6:0]  ext_shift;
  logic [68:0] fn_all;

  assign long_addr = (req_i.loco_address[13:7] != 7'd0);
  assign addr_b0   = long_addr ? (LongAddrTag | {2'b00, req_i.loco_address[13:8]})
                               : req_i.loco_address[7:0];
  assign addr_b1   = req_i.loco_address[7:0];

  assign grp       = 3'(req_i.packet_kind - KindExtFirst);
  assign ext_shift = 7'd13 + {1'b0, grp, 3'b000};
  assign fn_all    = {req_i.functions_high, req_i.functions_low};

  always_comb begin
    spd_sat  = req_i.speed;
    spd_code = 7'd0;
    v28      = 5'd0;
    data_b0  = 8'h00;
    data_b1  = 8'h00;
    two_data = 1'b0;
    kind_ok  = 1'b1;
    unique case (req_i.packet_kind) inside
      KindSpeed: begin
        unique case (req_i.step_mode)
          Mode128: begin
            spd_sat  = (req_i.speed > Spd128Max) ? Spd128Max : req_i.speed;
            spd_code = (spd_sat != 7'd0) ? spd_sat + 7'd1 : 7'd0;
            two_data = 1'b1;
            data_b0  = Adv128Code;
            data_b1  = (req_i.forward ? FwdBit128 : 8'h00) | {1'b0, spd_code};
          end
          Mode28: begin
            spd_sat = (req_i.speed > Spd28Max) ? Spd28Max : req_i.speed;
            v28     = (spd_sat != 7'd0) ? spd_sat[4:0] + 5'd3 : 5'd0;
            data_b0 = SpeedTag | (req_i.forward ? FwdBitBase : 8'h00)
                      | {3'b000, v28[0], v28[4:1]};
          end
          default: begin
            // Unused mode code is sent as 14 steps; F0 rides in bit 4.
            spd_sat  = (req_i.speed > Spd14Max) ? Spd14Max : req_i.speed;
            spd_code = (spd_sat != 7'd0) ? spd_sat + 7'd1 : 7'd0;
            data_b0  = SpeedTag | (req_i.forward ? FwdBitBase : 8'h00)
                       | {3'b000, req_i.functions_low[0], spd_code[3:0]}; 
          end
        endcase
      end
      KindF0F4: begin
        data_b0 = GrpF0F4Tag | {3'b000, req_i.functions_low[0], req_i.functions_low[4:1]};
      end
      KindF5F8: begin
        data_b0 = GrpF5F8Tag | {4'h0, req_i.functions_low[8:5]};
      end
      KindF9F12: begin
        data_b0 = GrpF9F12Tag | {4'h0, req_i.functions_low[12:9]};
      end
      [KindExtFirst:KindExtLast]: begin
        two_data = 1'b1;
        data_b0  = ext_group_code(grp);
        data_b1  = fn_all[ext_shift +: 8];
      end
      default: begin
        kind_ok = 1'b0;
      end
    endcase
  end

  assign chk = addr_b0 ^ (long_addr ? addr_b1 : 8'h00) ^ data_b0 ^ (two_data ? data_b1 : 8'h00);

  always_comb begin
    pkt_o.ok    = kind_ok;
    pkt_o.bytes = '0;
    pkt_o.len   = PktLenW'(3);
    unique case ({long_addr, two_data})
      2'b00: begin
        pkt_o.bytes[0] = addr_b0;
        pkt_o.bytes[1] = data_b0;
        pkt_o.bytes[2] = chk;
        pkt_o.len      = PktLenW'(3);
      end
      2'b01: begin
        pkt_o.bytes[0] = addr_b0;
        pkt_o.bytes[1] = data_b0;
        pkt_o.bytes[2] = data_b1;
        pkt_o.bytes[3] = chk;
        pkt_o.len      = PktLenW'(4);
      end
      2'b10: begin
        pkt_o.bytes[0] = addr_b0;
        pkt_o.bytes[1] = addr_b1;
        pkt_o.bytes[2] = data_b0;
        pkt_o.bytes[3] = chk;
        pkt_o.len      = PktLenW'(4);
      end
      default: begin
        pkt_o.bytes[0] = addr_b0;
        pkt_o.bytes[1] = addr_b1;
        pkt_o.bytes[2] = data_b0;
        pkt_o.bytes[3] = data_b1;
        pkt_o.bytes[4] = chk;
        pkt_o.len      = PktLenW'(5);
      end
    endcase
  end

endmodule

// ===== rtl/dcc_enc_ser.sv =====
// Packet buffer and byte serializer feeding the output stream.
module dcc_enc_ser import dcc_enc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pkt_valid_i,
  input  pkt_t       pkt_i,
  output logic       pkt_ready_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic       m_axis_tlast,
  output ser_stat_t  stat_o
);

  logic [PktMaxBytes-1:0][7:0] buf_q, buf_d;
  logic [PktLenW-1:0]          len_q, len_d;
  logic [PktIdxW-1:0]          idx_q, idx_d;
  logic                        busy_q, busy_d;
  logic                        last;
  logic                        done;
  logic                        can_load;

  assign last     = (PktLenW'(idx_q) == len_q - PktLenW'(1));
  assign done     = busy_q && m_axis_tready && last;
  assign can_load = !busy_q || done;

  assign pkt_ready_o   = can_load;
  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = buf_q[idx_q];
  assign m_axis_tlast  = last;

  assign stat_o.busy = busy_q;
  assign stat_o.idx  = idx_q;
  assign stat_o.len  = len_q;

  always_comb begin
    buf_d  = buf_q;
    len_d  = len_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    if (busy_q && m_axis_tready) begin
      // advance, or finish the packet on the error byte
      if (last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + PktIdxW'(1);
      end
    end
    if (pkt_valid_i && can_load) begin
      // drop requests of unused kinds without output
      if (pkt_i.ok) begin
        buf_d  = pkt_i.bytes;
        len_d  = pkt_i.len;
        idx_d  = '0;
        busy_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      len_q  <= PktLenW'(3);
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      len_q  <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

// ===== rtl/dcc_loco_packet_encoder.sv =====
// Top level of the DCC locomotive packet encoder.
//
//  channel  dir  tdata (low bit up)                                tuser        tlast
//  s_axis   in   address 14, mode 2, fwd 1, speed 7, fn_lo 64,     packet_kind  -
//                fn_hi 5, zero pad 3
//  m_axis   out  packet_byte 8                                     -            last_byte
//
// A request is held in the input register, then its packet of 3 to 5 bytes leaves at
// one word per cycle from the packet buffer while m_axis_tready is high. The next
// packet loads in the cycle the error byte is taken. Reset clears the valid flags
// of both stages. A stall on m_axis holds the current word and backs up into the
// input register, then into s_axis_tready.
`include "assert_macros.svh"

module dcc_loco_packet_encoder import dcc_enc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // loco_address[13:0], step_mode[15:14], forward[16], speed[23:17],
  // functions_low[87:24], functions_high[92:88], zero[95:93]
  input  logic [95:0] s_axis_tdata,
  // packet_kind[3:0]
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // packet_byte[7:0]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);

  req_t      req_q;
  logic      req_valid_q, req_valid_d;
  pkt_t      pkt;
  logic      pkt_ready;
  logic      in_take;
  logic      req_take;
  ser_stat_t stat;

  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign req_take      = req_valid_q && pkt_ready;
  assign s_axis_tready = !req_valid_q || pkt_ready;

  always_comb begin
    req_valid_d = req_valid_q;
    if (in_take) begin
      req_valid_d = 1'b1;
    end else if (req_take) begin
      req_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q.loco_address   <= s_axis_tdata[13:0];
      req_q.step_mode      <= s_axis_tdata[15:14];
      req_q.forward        <= s_axis_tdata[16];
      req_q.speed          <= s_axis_tdata[23:17];
      req_q.functions_low  <= s_axis_tdata[87:24];
      req_q.functions_high <= s_axis_tdata[92:88];
      req_q.packet_kind    <= s_axis_tuser;
    end
  end

  dcc_enc_build u_build (
    .req_i (req_q),
    .pkt_o (pkt)
  );

  dcc_enc_ser u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pkt_valid_i   (req_valid_q),
    .pkt_i         (pkt),
    .pkt_ready_o   (pkt_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .stat_o        (stat)
  );

  `ASSERT_IMP(a_idx_in_pkt, stat.busy, PktLenW'(stat.idx) < stat.len, "byte index past packet end")
  `ASSERT_IMP(a_len_range, stat.busy, stat.len >= PktLenW'(3) && stat.len <= PktLenW'(5), "bad packet length")
  `ASSERT_NXT(a_req_hold, req_valid_q && !pkt_ready, req_valid_q, "request lost while stalled")

endmodule
